### rtl/core/nptk_pkg.sv
// Shared constants for the nested priority interrupt tick controller.
`default_nettype none

package nptk_pkg;

  // Interrupt levels 0 .. NUM_LEVELS-1, user level sits at NUM_LEVELS
  localparam int NUM_LEVELS      = 6;
  localparam int USER_LEVEL      = NUM_LEVELS;
  localparam int MAX_IRQ_LENGTH  = 10;
  localparam int MAX_USER_LENGTH = 20;

  // Field widths
  localparam int LVL_W  = 3;
  localparam int LEN_W  = 5;
  localparam int PEND_W = 4;
  localparam int REM_W  = 5;
  localparam int MASK_W = 6;

  // Reported level when nothing ran
  localparam logic [LVL_W-1:0] IDLE_CODE = 3'd7;

endpackage : nptk_pkg

`default_nettype wire

### rtl/core/nested_priority_interrupt_tick.sv
// Nested priority interrupt controller advanced by one tick per accepted beat.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------------
//  tick    | in        | start_i high, busy_o low  | req_valid_i, req_level_i, req_length_i
//  result  | out       | done_o strobe, one cycle  | ran_level_o, level_finished_o,
//          |           |                           | req_accepted_o, pending_mask_o
//
// A tick beat is registered on acceptance; the next cycle resolves the request,
// the start decision and the spend against the level state and registers the
// result. start_i is registered into item_vld_q, and item_vld_q into done_o. One tick
// per cycle, busy_o stays low. Reset clears all pending and in-service counts at once.
// The receiver cannot stall; each result shows for exactly one cycle.
`default_nettype none

module nested_priority_interrupt_tick
  import nptk_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic              req_valid_i,
  input  wire logic [LVL_W-1:0]  req_level_i,
  input  wire logic [LEN_W-1:0]  req_length_i,
  output logic                   done_o,
  output logic [LVL_W-1:0]       ran_level_o,
  output logic                   level_finished_o,
  output logic                   req_accepted_o,
  output logic [MASK_W-1:0]      pending_mask_o
);

  // Input stage
  logic              item_vld_q;
  logic              in_valid_q;
  logic [LVL_W-1:0]  in_level_q;
  logic [LEN_W-1:0]  in_length_q;

  // Level state
  logic [PEND_W-1:0] pend_q [NUM_LEVELS];
  logic [PEND_W-1:0] pend_d [NUM_LEVELS];
  logic [REM_W-1:0]  rem_q  [NUM_LEVELS+1];
  logic [REM_W-1:0]  rem_d  [NUM_LEVELS+1];

  // Resolve stage signals
  logic              run0_vld, run1_vld, run2_vld, top_vld, do_start;
  logic [LVL_W-1:0]  run0, run1, run2, top;
  logic [PEND_W-1:0] irq_len;
  logic [REM_W-1:0]  usr_len;
  logic              accept, finished;
  logic [LVL_W-1:0]  ran;
  logic [MASK_W-1:0] mask;

  assign busy_o = 1'b0;

  // Saturate request lengths; zero counts as one tick
  always_comb begin
    if (in_length_q == '0) begin
      irq_len = PEND_W'(1);
    end else if (in_length_q > LEN_W'(MAX_IRQ_LENGTH)) begin
      irq_len = PEND_W'(MAX_IRQ_LENGTH);
    end else begin
      irq_len = in_length_q[PEND_W-1:0];
    end
    if (in_length_q == '0) begin
      usr_len = REM_W'(1);
    end else if (in_length_q > LEN_W'(MAX_USER_LENGTH)) begin
      usr_len = REM_W'(MAX_USER_LENGTH);
    end else begin
      usr_len = in_length_q;
    end
  end

  // Request check, start, spend for one tick
  always_comb begin
    pend_d   = pend_q;
    rem_d    = rem_q;
    accept   = 1'b0;
    finished = 1'b0;

    // running level at tick start
    run0_vld = 1'b0;
    run0     = '0;
    for (int i = NUM_LEVELS; i >= 0; i--) begin
      if (rem_q[i] != '0) begin
        run0_vld = 1'b1;
        run0     = LVL_W'(i);
      end
    end

    // take the request
    if (item_vld_q && in_valid_q) begin
      if (in_level_q < LVL_W'(NUM_LEVELS)) begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
          if (in_level_q == LVL_W'(i) && pend_q[i] == '0 &&
              !(run0_vld && run0 == LVL_W'(i))) begin
            pend_d[i] = irq_len;
            accept    = 1'b1;
          end
        end
      end else if (in_level_q == LVL_W'(USER_LEVEL)) begin
        if (rem_q[USER_LEVEL] == '0) begin
          rem_d[USER_LEVEL] = usr_len;
          accept            = 1'b1;
        end
      end
    end

    // most urgent pending level
    top_vld = 1'b0;
    top     = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (pend_d[i] != '0) begin
        top_vld = 1'b1;
        top     = LVL_W'(i);
      end
    end

    // running level after the request
    run1_vld = 1'b0;
    run1     = '0;
    for (int i = NUM_LEVELS; i >= 0; i--) begin
      if (rem_d[i] != '0) begin
        run1_vld = 1'b1;
        run1     = LVL_W'(i);
      end
    end

    // preempt when the pending level is more urgent
    do_start = item_vld_q && top_vld && (!run1_vld || top < run1);
    if (do_start) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        if (top == LVL_W'(i)) begin
          rem_d[i]  = REM_W'(pend_d[i]);
          pend_d[i] = '0;
        end
      end
    end

    run2_vld = do_start || run1_vld;
    run2     = do_start ? top : run1;

    // spend one tick on the running level
    if (item_vld_q && run2_vld) begin
      for (int i = 0; i <= NUM_LEVELS; i++) begin
        if (run2 == LVL_W'(i)) begin
          finished = (rem_d[i] == REM_W'(1));
          rem_d[i] = rem_d[i] - REM_W'(1);
        end
      end
    end

    ran = run2_vld ? run2 : IDLE_CODE;

    mask = '0;
    for (int i = 0; i < NUM_LEVELS && i < MASK_W; i++) begin
      mask[i] = (pend_d[i] != '0);
    end
  end

  // Hold control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      done_o     <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        pend_q[i] <= '0;
      end
      for (int i = 0; i <= NUM_LEVELS; i++) begin
        rem_q[i] <= '0;
      end
    end else begin
      item_vld_q <= start_i && !busy_o;
      done_o     <= item_vld_q;
      pend_q     <= pend_d;
      rem_q      <= rem_d;
    end
  end

  // Capture the tick beat and the result beat
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_valid_q  <= req_valid_i;
      in_level_q  <= req_level_i;
      in_length_q <= req_length_i;
    end
    if (item_vld_q) begin
      ran_level_o      <= ran;
      level_finished_o <= finished;
      req_accepted_o   <= accept;
      pending_mask_o   <= mask;
    end
  end

`ifndef ASSERT_OFF
  // Every accepted tick yields one result beat on done_o
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> ##1 done_o)
    else $error("tick beat without result beat");

  // A finish is only reported for a level that ran
  a_finish_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && level_finished_o |-> ran_level_o != IDLE_CODE)
    else $error("finish reported on an idle tick");

  // An accepted request needs a request on its tick
  a_accept_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && req_accepted_o |-> $past(req_valid_i, 2))
    else $error("request accepted without a request");
`endif

endmodule : nested_priority_interrupt_tick

`default_nettype wire
